/* hw/rtl/wat_pkg.sv */
// ----------------------------------------------------------------------------
// wat_pkg: shared types and constants of the weekly alarm table matcher
// Word formats, mode and status codes, table sizing and the time helper.
// ----------------------------------------------------------------------------
package wat_pkg;

    localparam int MAX_ALARMS = 16;
    localparam int CNT_W      = $clog2(MAX_ALARMS + 1);
    localparam int ADDR_W     = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
    localparam int INDEX_W    = 4;
    localparam int CMP_W      = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int USED_W     = 5;
    localparam int MIN_W      = 11;

    typedef enum logic [1:0] {
        MODE_SET   = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_DEL   = 2'd2,
        MODE_CHECK = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_mode              mode;
        logic [INDEX_W-1:0] index;
        logic               entry_enabled;
        logic [7:0]         entry_days;
        logic [MIN_W-1:0]   entry_minute;
        logic [2:0]         now_weekday;
        logic [4:0]         now_hour;
        logic [5:0]         now_minute;
    } t_in_word;

    typedef struct packed {
        logic              fire;
        t_status           status;
        logic [USED_W-1:0] used_count;
    } t_out_word;

    typedef struct packed {
        logic             enabled;
        logic [7:0]       days;
        logic [MIN_W-1:0] minute;
    } t_alarm;

    // hour * 60 + minute as (hour << 6) - (hour << 2) + minute
    function automatic logic [MIN_W-1:0] now_of_day(input logic [4:0] hour,
                                                    input logic [5:0] mins);
        logic [MIN_W-1:0] a;
        logic [MIN_W-1:0] b;
        logic [MIN_W-1:0] c;
        a = {hour, 6'd0};
        b = {4'd0, hour, 2'd0};
        c = {5'd0, mins};
        return a - b + c;
    endfunction

endpackage

/* hw/rtl/wat_ram.sv */
// ----------------------------------------------------------------------------
// wat_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module wat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/wat_match.sv */
// ----------------------------------------------------------------------------
// wat_match: alarm compare unit
// Flag an entry that is enabled, has today's day bit and matches the minute.
// ----------------------------------------------------------------------------
module wat_match (
    input  wat_pkg::t_alarm              i_entry,
    input  logic [2:0]                   i_weekday,
    input  logic [wat_pkg::MIN_W-1:0]    i_now,
    output logic                         o_hit
);

    assign o_hit = i_entry.enabled && i_entry.days[i_weekday] && (i_entry.minute == i_now);

endmodule

/* hw/rtl/weekly_alarm_table_matcher.sv */
// ----------------------------------------------------------------------------
// weekly_alarm_table_matcher: alarm table with set, add, delete and check
// Table of weekly alarms in a small RAM, walked by a sequencer through one
// shared compare unit.
// ----------------------------------------------------------------------------
// One input word is taken at a time; o_in_stall stays high while it is at
// work. Set and add write the RAM in the accept cycle and the result is
// registered from S_DONE once the output register is free. Check walks the
// used entries one per cycle through the compare unit, pipelined against the
// registered RAM read, and stops early when an alarm fires. Delete moves the
// later entries down one per cycle through the same RAM read/write ports. A
// new word is accepted while the last result still waits in the output
// register; a result waits in the sequencer only if that register is still
// full. Fire is 1 only for a check that finds a newly triggered alarm; status
// reports index out of range or table full.
// ----------------------------------------------------------------------------
module weekly_alarm_table_matcher (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  wat_pkg::t_in_word    i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output wat_pkg::t_out_word   o_out_word
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_DEL  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [wat_pkg::CNT_W-1:0]     r_count, n_count;
    logic [wat_pkg::MAX_ALARMS-1:0] r_latch, n_latch;
    logic [wat_pkg::CNT_W-1:0]     r_ptr, n_ptr;
    logic                          r_cmp_valid, n_cmp_valid;
    logic [wat_pkg::ADDR_W-1:0]    r_cmp_idx, n_cmp_idx;
    logic [2:0]                    r_wday, n_wday;
    logic [wat_pkg::MIN_W-1:0]     r_now, n_now;
    logic                          r_fire, n_fire;
    wat_pkg::t_status              r_status, n_status;
    logic                          r_out_valid, n_out_valid;
    wat_pkg::t_out_word            r_out, n_out;

    // RAM ports
    logic                          ram_we;
    logic [wat_pkg::ADDR_W-1:0]    ram_waddr;
    wat_pkg::t_alarm               ram_wdata;
    logic [wat_pkg::ADDR_W-1:0]    ram_raddr;
    logic [$bits(wat_pkg::t_alarm)-1:0] ram_rdata;
    wat_pkg::t_alarm               rd_entry;
    logic                          hit;

    logic                          accept;
    logic                          idx_ok;
    logic                          more;
    logic                          out_free;
    wat_pkg::t_alarm               in_entry;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign idx_ok   = wat_pkg::CMP_W'(i_in_word.index) < wat_pkg::CMP_W'(r_count);
    assign more     = r_ptr < r_count;
    assign out_free = !r_out_valid || !i_out_stall;
    assign rd_entry = wat_pkg::t_alarm'(ram_rdata);

    assign in_entry.enabled = i_in_word.entry_enabled;
    assign in_entry.days    = i_in_word.entry_days;
    assign in_entry.minute  = i_in_word.entry_minute;

    wat_ram #(
        .WIDTH ($bits(wat_pkg::t_alarm)),
        .DEPTH (wat_pkg::MAX_ALARMS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    wat_match u_match (
        .i_entry   (rd_entry),
        .i_weekday (r_wday),
        .i_now     (r_now),
        .o_hit     (hit)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_latch     = r_latch;
        n_ptr       = r_ptr;
        n_cmp_valid = r_cmp_valid;
        n_cmp_idx   = r_cmp_idx;
        n_wday      = r_wday;
        n_now       = r_now;
        n_fire      = r_fire;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_cmp_idx - wat_pkg::ADDR_W'(1);
        ram_wdata   = rd_entry;
        ram_raddr   = r_ptr[wat_pkg::ADDR_W-1:0];

        // drop the output word once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_fire   = 1'b0;
                    n_status = wat_pkg::ST_OK;
                    unique case (i_in_word.mode)
                        wat_pkg::MODE_SET: begin
                            n_state = S_DONE;
                            if (idx_ok) begin
                                ram_we    = 1'b1;
                                ram_waddr = wat_pkg::ADDR_W'(i_in_word.index);
                                ram_wdata = in_entry;
                                n_latch[wat_pkg::ADDR_W'(i_in_word.index)] = 1'b0;
                            end else begin
                                n_status = wat_pkg::ST_RANGE;
                            end
                        end
                        wat_pkg::MODE_ADD: begin
                            n_state = S_DONE;
                            if (r_count < wat_pkg::CNT_W'(wat_pkg::MAX_ALARMS)) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[wat_pkg::ADDR_W-1:0];
                                ram_wdata = in_entry;
                                n_latch[r_count[wat_pkg::ADDR_W-1:0]] = 1'b0;
                                n_count   = r_count + wat_pkg::CNT_W'(1);
                            end else begin
                                n_status = wat_pkg::ST_FULL;
                            end
                        end
                        wat_pkg::MODE_DEL: begin
                            if (idx_ok) begin
                                // shift latches down; slots above the count hold zero
                                for (int j = 0; j < wat_pkg::MAX_ALARMS; j++) begin
                                    if (wat_pkg::CMP_W'(j) >= wat_pkg::CMP_W'(i_in_word.index))
                                    begin
                                        n_latch[j] = (j == wat_pkg::MAX_ALARMS - 1) ?
                                                     1'b0 : r_latch[(j + 1) % wat_pkg::MAX_ALARMS];
                                    end
                                end
                                n_ptr       = wat_pkg::CNT_W'(i_in_word.index) +
                                              wat_pkg::CNT_W'(1);
                                n_cmp_valid = 1'b0;
                                n_state     = S_DEL;
                            end else begin
                                n_status = wat_pkg::ST_RANGE;
                                n_state  = S_DONE;
                            end
                        end
                        wat_pkg::MODE_CHECK: begin
                            n_wday      = i_in_word.now_weekday;
                            n_now       = wat_pkg::now_of_day(i_in_word.now_hour,
                                                              i_in_word.now_minute);
                            n_ptr       = '0;
                            n_cmp_valid = 1'b0;
                            n_state     = S_WALK;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // issue the next read while judging the entry read last cycle
                n_cmp_valid = more;
                n_cmp_idx   = r_ptr[wat_pkg::ADDR_W-1:0];
                if (more) begin
                    n_ptr = r_ptr + wat_pkg::CNT_W'(1);
                end
                if (r_cmp_valid) begin
                    if (hit) begin
                        if (!r_latch[r_cmp_idx]) begin
                            n_latch[r_cmp_idx] = 1'b1;
                            n_fire             = 1'b1;
                            n_state            = S_DONE;
                        end
                    end else begin
                        n_latch[r_cmp_idx] = 1'b0;
                    end
                end else if (!more) begin
                    n_state = S_DONE;
                end
            end
            S_DEL: begin
                // move entry read last cycle one slot down
                n_cmp_valid = more;
                n_cmp_idx   = r_ptr[wat_pkg::ADDR_W-1:0];
                if (more) begin
                    n_ptr = r_ptr + wat_pkg::CNT_W'(1);
                end
                if (r_cmp_valid) begin
                    ram_we = 1'b1;
                end else if (!more) begin
                    n_count = r_count - wat_pkg::CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (out_free) begin
                    n_out.fire       = r_fire;
                    n_out.status     = r_status;
                    n_out.used_count = wat_pkg::USED_W'(r_count);
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_latch     <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_latch     <= n_latch;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
        end
        r_ptr     <= n_ptr;
        r_cmp_idx <= n_cmp_idx;
        r_wday    <= n_wday;
        r_now     <= n_now;
        r_fire    <= n_fire;
        r_status  <= n_status;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
